>>> rtl/core/pitu_pkg.sv
// Shared types and codes for the pair interning table.
package pitu_pkg;

    localparam logic       KIND_INSERT = 1'b0;
    localparam logic       KIND_REDUCE = 1'b1;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam int VALUE_W = 16;
    localparam int KEY_W   = 32;
    localparam int LEVEL_W = 2;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 3;
    localparam logic [POS_W-1:0] POS_MAX = 3'd7;

    typedef enum logic {
        SR_IDLE,
        SR_SCAN
    } t_srch_state;

    typedef enum logic {
        TS_IDLE,
        TS_WAIT
    } t_top_state;

    typedef struct packed {
        logic done;
        logic found;
    } t_srch_rsp;

endpackage

>>> rtl/core/pitu_entry_mem.sv
// Entry storage: one write port and one registered read port.
module pitu_entry_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 48
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/pitu_search.sv
// Linear search of one level's entries with a single shared key comparator.
module pitu_search #(
    parameter int AW    = 12,
    parameter int IDW   = 16,
    parameter int CNT_W = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [AW-1:0]                       i_base,
    input  logic [pitu_pkg::KEY_W-1:0]          i_key,
    input  logic [CNT_W-1:0]                    i_count,
    output logic                                o_rd_en,
    output logic [AW-1:0]                       o_rd_addr,
    input  logic [pitu_pkg::KEY_W+IDW-1:0]      i_rd_data,
    output pitu_pkg::t_srch_rsp                 o_rsp,
    output logic [IDW-1:0]                      o_ident
);

    pitu_pkg::t_srch_state r_state, n_state;
    logic [AW-1:0]                 r_addr, n_addr;
    logic [CNT_W-1:0]              r_left, n_left;
    logic                          r_pend, n_pend;
    logic [pitu_pkg::KEY_W-1:0]    r_key, n_key;
    logic                          r_done, n_done;
    logic                          r_found, n_found;
    logic [IDW-1:0]                r_ident, n_ident;
    logic                          hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pitu_pkg::SR_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_left  <= n_left;
        r_key   <= n_key;
        r_found <= n_found;
        r_ident <= n_ident;
    end

    // Read data arrives in the cycle after the address, so the compare trails the issue.
    assign hit = r_pend && (i_rd_data[pitu_pkg::KEY_W+IDW-1:IDW] == r_key);

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_left    = r_left;
        n_pend    = r_pend;
        n_key     = r_key;
        n_done    = 1'b0;
        n_found   = r_found;
        n_ident   = r_ident;
        o_rd_en   = 1'b0;
        o_rd_addr = r_addr;
        unique case (r_state)
            pitu_pkg::SR_IDLE: begin
                if (i_start) begin
                    n_addr  = i_base;
                    n_left  = i_count;
                    n_key   = i_key;
                    n_pend  = 1'b0;
                    n_state = pitu_pkg::SR_SCAN;
                end
            end
            pitu_pkg::SR_SCAN: begin
                if (hit) begin
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_ident = i_rd_data[IDW-1:0];
                    n_pend  = 1'b0;
                    n_state = pitu_pkg::SR_IDLE;
                end else if (r_left != '0) begin
                    o_rd_en = 1'b1;
                    n_addr  = r_addr + AW'(1);
                    n_left  = r_left - CNT_W'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_done  = 1'b1;
                    n_found = 1'b0;
                    n_pend  = 1'b0;
                    n_state = pitu_pkg::SR_IDLE;
                end
            end
            default: begin
                n_state = pitu_pkg::SR_IDLE;
            end
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.found = r_found;
    assign o_ident     = r_ident;

endmodule

>>> rtl/core/pair_interning_table_unit.sv
// Pair interning table: per-level pair dictionaries with a shared identifier counter.
// An insert, or a reduce element from the third on, scans its level one entry per cycle;
// busy stays high for the whole scan, the result strobes in the cycle after busy's last high
// cycle, and no new item is taken while busy is high. The first two reduce elements keep busy
// low, one per cycle. Results cannot be stalled. Synchronous reset clears counts, the
// identifier counter and reduce state, but not the entry memory.
module pair_interning_table_unit #(
    parameter int LEVELS            = 4,
    parameter int ENTRIES_PER_LEVEL = 1024,
    parameter int ID_WIDTH          = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_kind,
    input  logic [pitu_pkg::VALUE_W-1:0]     i_left_value,
    input  logic [pitu_pkg::VALUE_W-1:0]     i_right_value,
    input  logic [pitu_pkg::LEVEL_W-1:0]     i_level,
    input  logic                             i_last_element,
    output logic                             o_result_valid,
    output logic [pitu_pkg::VALUE_W-1:0]     o_result_first,
    output logic [pitu_pkg::VALUE_W-1:0]     o_result_second,
    output logic [1:0]                       o_status,
    output logic [pitu_pkg::COUNT_W-1:0]     o_level_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pitu_pkg::VALUE_W-1:0]     i_cfg_data
);

    localparam int DEPTH = LEVELS * ENTRIES_PER_LEVEL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(ENTRIES_PER_LEVEL + 1);
    localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW    = ((ID_WIDTH > pitu_pkg::VALUE_W) ? ID_WIDTH : pitu_pkg::VALUE_W) + 1;
    localparam int DW    = pitu_pkg::KEY_W + ID_WIDTH;
    localparam logic [CW-1:0]    ID_MAX  = CW'((64'd1 << ID_WIDTH) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES_PER_LEVEL);

    localparam int VW = pitu_pkg::VALUE_W;

    pitu_pkg::t_top_state r_state, n_state;
    logic [CNT_W-1:0]            r_counts [LEVELS];
    logic [CNT_W-1:0]            n_counts [LEVELS];
    logic [CW-1:0]               r_next_id, n_next_id;
    logic [pitu_pkg::KEY_W-1:0]  r_pair, n_pair;
    logic [pitu_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                        r_missed, n_missed;
    logic                        r_kind, n_kind;
    logic                        r_last, n_last;
    logic [VW-1:0]               r_elem, n_elem;
    logic [pitu_pkg::KEY_W-1:0]  r_key, n_key;
    logic [LIW-1:0]              r_lvl, n_lvl;
    logic [AW-1:0]               r_base, n_base;
    logic                        r_out_valid, n_out_valid;
    logic [VW-1:0]               r_out_first, n_out_first;
    logic [VW-1:0]               r_out_second, n_out_second;
    logic [1:0]                  r_out_status, n_out_status;
    logic [pitu_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    logic                        srch_start;
    logic [AW-1:0]               srch_base;
    logic [pitu_pkg::KEY_W-1:0]  srch_key;
    logic [CNT_W-1:0]            srch_count;
    pitu_pkg::t_srch_rsp         srch_rsp;
    logic [ID_WIDTH-1:0]         srch_ident;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [DW-1:0]               rd_data;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [DW-1:0]               wr_data;

    logic                        take;
    logic                        ins_ok;
    logic [pitu_pkg::POS_W-1:0]  red_lvl;
    logic                        red_ok;
    logic [LIW-1:0]              red_idx;
    logic [CNT_W-1:0]            cur_count;
    logic                        exhausted;
    logic [VW-1:0]               found_id;
    logic [pitu_pkg::KEY_W-1:0]  upd_pair;
    logic                        upd_missed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pitu_pkg::TS_IDLE;
            r_next_id   <= '0;
            r_pair      <= '0;
            r_pos       <= '0;
            r_missed    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_next_id   <= n_next_id;
            r_pair      <= n_pair;
            r_pos       <= n_pos;
            r_missed    <= n_missed;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < LEVELS; i++) begin
                r_counts[i] <= n_counts[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_last       <= n_last;
        r_elem       <= n_elem;
        r_key        <= n_key;
        r_lvl        <= n_lvl;
        r_base       <= n_base;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign busy        = (r_state != pitu_pkg::TS_IDLE);
    assign o_cfg_ready = (r_state == pitu_pkg::TS_IDLE);
    assign take        = start && !busy;

    assign ins_ok    = (32'(i_level) < LEVELS);
    assign red_lvl   = r_pos - pitu_pkg::POS_W'(2);
    assign red_ok    = (32'(red_lvl) < LEVELS);
    assign red_idx   = LIW'(red_lvl);
    assign cur_count = r_counts[r_lvl];
    assign exhausted = (r_next_id > ID_MAX);
    assign found_id  = srch_rsp.found ? VW'(srch_ident) : '0;
    assign upd_pair  = {found_id, r_elem};
    assign upd_missed = r_missed || !srch_rsp.found;

    always_comb begin
        n_state      = r_state;
        n_counts     = r_counts;
        n_next_id    = r_next_id;
        n_pair       = r_pair;
        n_pos        = r_pos;
        n_missed     = r_missed;
        n_kind       = r_kind;
        n_last       = r_last;
        n_elem       = r_elem;
        n_key        = r_key;
        n_lvl        = r_lvl;
        n_base       = r_base;
        n_out_valid  = 1'b0;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        srch_start   = 1'b0;
        srch_base    = r_base;
        srch_key     = r_key;
        srch_count   = '0;
        wr_en        = 1'b0;
        wr_addr      = r_base + AW'(cur_count);
        wr_data      = {r_key, r_next_id[ID_WIDTH-1:0]};

        unique case (r_state)
            pitu_pkg::TS_IDLE: begin
                if (i_cfg_valid) begin
                    n_next_id = CW'(i_cfg_data);
                end
                if (take) begin
                    n_kind = i_kind;
                    n_last = i_last_element;
                    n_elem = i_left_value;
                    if (i_kind == pitu_pkg::KIND_INSERT) begin
                        if (!ins_ok) begin
                            n_out_valid  = 1'b1;
                            n_out_first  = '0;
                            n_out_second = '0;
                            n_out_status = pitu_pkg::ST_FULL;
                            n_out_count  = '0;
                        end else begin
                            n_key      = {i_left_value, i_right_value};
                            n_lvl      = LIW'(i_level);
                            n_base     = AW'(32'(i_level) * ENTRIES_PER_LEVEL);
                            srch_start = 1'b1;
                            srch_base  = n_base;
                            srch_key   = n_key;
                            srch_count = r_counts[n_lvl];
                            n_state    = pitu_pkg::TS_WAIT;
                        end
                    end else if (r_pos < pitu_pkg::POS_W'(2)) begin
                        // The first two elements only build the running pair.
                        if (r_pos == '0) begin
                            n_pair = {i_left_value, {VW{1'b0}}};
                        end else begin
                            n_pair = {r_pair[pitu_pkg::KEY_W-1:VW], i_left_value};
                        end
                        if (i_last_element) begin
                            n_out_valid  = 1'b1;
                            n_out_first  = n_pair[pitu_pkg::KEY_W-1:VW];
                            n_out_second = n_pair[VW-1:0];
                            n_out_status = ((r_pos == '0) || r_missed) ?
                                           pitu_pkg::ST_MISS : pitu_pkg::ST_FOUND;
                            n_out_count  = '0;
                            n_pair       = '0;
                            n_pos        = '0;
                            n_missed     = 1'b0;
                        end else begin
                            n_pos = r_pos + pitu_pkg::POS_W'(1);
                        end
                    end else begin
                        // A level that does not exist scans nothing and so misses.
                        n_key      = r_pair;
                        n_base     = red_ok ? AW'(32'(red_lvl) * ENTRIES_PER_LEVEL) : '0;
                        srch_start = 1'b1;
                        srch_base  = n_base;
                        srch_key   = r_pair;
                        srch_count = red_ok ? r_counts[red_idx] : '0;
                        n_state    = pitu_pkg::TS_WAIT;
                    end
                end
            end
            pitu_pkg::TS_WAIT: begin
                if (srch_rsp.done) begin
                    n_state = pitu_pkg::TS_IDLE;
                    if (r_kind == pitu_pkg::KIND_INSERT) begin
                        n_out_valid  = 1'b1;
                        n_out_second = '0;
                        if (srch_rsp.found) begin
                            n_out_first  = VW'(srch_ident);
                            n_out_status = pitu_pkg::ST_FOUND;
                            n_out_count  = pitu_pkg::COUNT_W'(cur_count);
                        end else if ((cur_count == CNT_MAX) || exhausted) begin
                            n_out_first  = '0;
                            n_out_status = pitu_pkg::ST_FULL;
                            n_out_count  = pitu_pkg::COUNT_W'(cur_count);
                        end else begin
                            wr_en           = 1'b1;
                            n_counts[r_lvl] = cur_count + CNT_W'(1);
                            n_next_id       = r_next_id + CW'(1);
                            n_out_first     = VW'(r_next_id[ID_WIDTH-1:0]);
                            n_out_status    = pitu_pkg::ST_NEW;
                            n_out_count     = pitu_pkg::COUNT_W'(n_counts[r_lvl]);
                        end
                    end else if (r_last) begin
                        n_out_valid  = 1'b1;
                        n_out_first  = upd_pair[pitu_pkg::KEY_W-1:VW];
                        n_out_second = upd_pair[VW-1:0];
                        n_out_status = upd_missed ? pitu_pkg::ST_MISS : pitu_pkg::ST_FOUND;
                        n_out_count  = '0;
                        n_pair       = '0;
                        n_pos        = '0;
                        n_missed     = 1'b0;
                    end else begin
                        n_pair   = upd_pair;
                        n_missed = upd_missed;
                        if (r_pos != pitu_pkg::POS_MAX) begin
                            n_pos = r_pos + pitu_pkg::POS_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = pitu_pkg::TS_IDLE;
            end
        endcase
    end

    pitu_search #(
        .AW    (AW),
        .IDW   (ID_WIDTH),
        .CNT_W (CNT_W)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (srch_start),
        .i_base    (srch_base),
        .i_key     (srch_key),
        .i_count   (srch_count),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_rsp     (srch_rsp),
        .o_ident   (srch_ident)
    );

    pitu_entry_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_result_valid  = r_out_valid;
    assign o_result_first  = r_out_first;
    assign o_result_second = r_out_second;
    assign o_status        = r_out_status;
    assign o_level_count   = r_out_count;

endmodule

>>> tb/sv/pair_interning_table_unit_tb.sv
// Self-checking testbench for the pair interning table: directed cases, random traffic, then a level fill.
`timescale 1ns / 1ps

module pair_interning_table_unit_tb;

    localparam int LEVELS  = 4;
    localparam int ENTRIES = 1024;
    localparam int SETTLE  = ENTRIES + 16;

    localparam int VALUE_W = pitu_pkg::VALUE_W;
    localparam int KEY_W   = pitu_pkg::KEY_W;
    localparam int LEVEL_W = pitu_pkg::LEVEL_W;
    localparam int COUNT_W = pitu_pkg::COUNT_W;
    localparam int POS_W   = pitu_pkg::POS_W;

    typedef struct packed {
        logic                kind;
        logic [VALUE_W-1:0]  left;
        logic [VALUE_W-1:0]  right;
        logic [LEVEL_W-1:0]  level;
        logic                last;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  first;
        logic [VALUE_W-1:0]  second;
        logic [1:0]          status;
        logic [COUNT_W-1:0]  count;
    } t_result;

    // Mirror of the dictionaries and the reduce stream, plus the results still owed.
    class interning_checker;
        logic [KEY_W-1:0]    pair_key [LEVELS][ENTRIES];
        logic [VALUE_W-1:0]  pair_id  [LEVELS][ENTRIES];
        logic [COUNT_W-1:0]  held     [LEVELS];
        logic [VALUE_W:0]    next_id;
        logic [KEY_W-1:0]    running;
        logic [POS_W-1:0]    position;
        logic                missed;
        t_result             awaited [$];
        int                  mismatches;

        function new();
            foreach (held[i]) held[i] = '0;
            next_id    = '0;
            running    = '0;
            position   = '0;
            missed     = 1'b0;
            mismatches = 0;
        endfunction

        function void load_start_index(logic [VALUE_W-1:0] value);
            next_id = {1'b0, value};
        endfunction

        function bit find_id(int lvl, logic [KEY_W-1:0] key, output logic [VALUE_W-1:0] id);
            int i;
            id = '0;
            if (lvl >= LEVELS) return 0;
            for (i = 0; i < held[lvl]; i++) begin
                if (pair_key[lvl][i] == key) begin
                    id = pair_id[lvl][i];
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_item(t_item it);
            t_result            r;
            logic [VALUE_W-1:0] id;
            logic [KEY_W-1:0]   key;
            int                 lv;
            if (it.kind == pitu_pkg::KIND_INSERT) begin
                key      = {it.left, it.right};
                lv       = int'(it.level);
                r.second = '0;
                if (lv >= LEVELS) begin
                    r.first  = '0;
                    r.status = pitu_pkg::ST_FULL;
                    r.count  = '0;
                end else if (find_id(lv, key, id)) begin
                    r.first  = id;
                    r.status = pitu_pkg::ST_FOUND;
                    r.count  = held[lv];
                end else if (held[lv] >= ENTRIES || next_id[VALUE_W]) begin
                    r.first  = '0;
                    r.status = pitu_pkg::ST_FULL;
                    r.count  = held[lv];
                end else begin
                    pair_key[lv][held[lv]] = key;
                    pair_id[lv][held[lv]]  = next_id[VALUE_W-1:0];
                    r.first  = next_id[VALUE_W-1:0];
                    next_id++;
                    held[lv]++;
                    r.status = pitu_pkg::ST_NEW;
                    r.count  = held[lv];
                end
                awaited = {awaited, r};
            end else begin
                if (position == 0) begin
                    running = {it.left, 16'h0000};
                end else if (position == 1) begin
                    running[VALUE_W-1:0] = it.left;
                end else begin
                    if (!find_id(int'(position) - 2, running, id)) begin
                        id     = '0;
                        missed = 1'b1;
                    end
                    running = {id, it.left};
                end
                if (it.last) begin
                    r.first  = running[KEY_W-1:VALUE_W];
                    r.second = running[VALUE_W-1:0];
                    r.status = (position == 0 || missed) ? pitu_pkg::ST_MISS
                                                          : pitu_pkg::ST_FOUND;
                    r.count  = '0;
                    awaited  = {awaited, r};
                    running  = '0;
                    position = '0;
                    missed   = 1'b0;
                end else if (position != pitu_pkg::POS_MAX) begin
                    position++;
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: unexpected result first=%h second=%h st=%0d count=%0d",
                             $realtime, got.first, got.second, got.status, got.count);
                return;
            end
            exp = awaited.pop_front();
            if (got.first !== exp.first || got.second !== exp.second ||
                got.status !== exp.status || got.count !== exp.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%t: mismatch expected %h/%h st=%0d count=%0d,",
                              " got %h/%h st=%0d count=%0d"},
                             $realtime, exp.first, exp.second, exp.status, exp.count,
                             got.first, got.second, got.status, got.count);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_kind;
    logic [VALUE_W-1:0]  i_left_value;
    logic [VALUE_W-1:0]  i_right_value;
    logic [LEVEL_W-1:0]  i_level;
    logic                i_last_element;
    logic                o_result_valid;
    logic [VALUE_W-1:0]  o_result_first;
    logic [VALUE_W-1:0]  o_result_second;
    logic [1:0]          o_status;
    logic [COUNT_W-1:0]  o_level_count;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [VALUE_W-1:0]  i_cfg_data;

    interning_checker chk;
    int               idle_pct;
    int               items_sent;

    pair_interning_table_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_left_value   (i_left_value),
        .i_right_value  (i_right_value),
        .i_level        (i_level),
        .i_last_element (i_last_element),
        .o_result_valid (o_result_valid),
        .o_result_first (o_result_first),
        .o_result_second(o_result_second),
        .o_status       (o_status),
        .o_level_count  (o_level_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100000000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            chk.check_result({o_result_first, o_result_second, o_status, o_level_count});
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 30) return VALUE_W'($urandom_range(7));
        if (r < 35) return 16'h0000;
        if (r < 40) return 16'hFFFF;
        return VALUE_W'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer with start
    // still high, so a following item can go out back to back.
    task automatic send_item(input logic kind, input logic [VALUE_W-1:0] lv,
                             input logic [VALUE_W-1:0] rv, input logic [LEVEL_W-1:0] lev,
                             input logic last);
        t_item it;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        it = {kind, lv, rv, lev, last};
        i_kind         <= kind;
        i_left_value   <= lv;
        i_right_value  <= rv;
        i_level        <= lev;
        i_last_element <= last;
        start          <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        chk.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_insert(input logic [VALUE_W-1:0] lv, input logic [VALUE_W-1:0] rv,
                               input logic [LEVEL_W-1:0] lev);
        send_item(pitu_pkg::KIND_INSERT, lv, rv, lev, 1'($urandom_range(1)));
    endtask

    task automatic send_reduce(input logic [VALUE_W-1:0] element, input logic last);
        send_item(pitu_pkg::KIND_REDUCE, element, VALUE_W'($urandom),
                  LEVEL_W'($urandom_range(3)), last);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (chk.awaited.size() != 0) @(negedge i_clk);
    endtask

    // A reduce element that yields no result may still be scanning, so let it finish.
    task automatic write_start_index(input logic [VALUE_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        chk.load_start_index(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Builds the dictionary entries a vector needs, then streams the vector itself.
    task automatic send_chain();
        logic [VALUE_W-1:0] elem [8];
        logic [VALUE_W-1:0] cur;
        logic [VALUE_W-1:0] id;
        int                 len;
        int                 k;
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 8) : $urandom_range(1, 6);
        for (k = 0; k < 8; k++) elem[k] = pick_value();
        cur = elem[0];
        for (k = 0; k <= len - 3 && k < LEVELS; k++) begin
            if ($urandom_range(9) != 0) send_insert(cur, elem[k+1], LEVEL_W'(k));
            if (!chk.find_id(k, {cur, elem[k+1]}, id)) id = '0;
            cur = id;
        end
        for (k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0)
                send_insert(pick_value(), pick_value(), LEVEL_W'($urandom_range(3)));
            send_reduce(elem[k], k == len - 1);
        end
    endtask

    task automatic run_random(input int pct, input int count);
        int target;
        int r;
        int lv;
        int idx;
        int k;
        int len;
        idle_pct = pct;
        target   = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_chain();
            end else if (r < 75) begin
                send_insert(pick_value(), pick_value(), LEVEL_W'($urandom_range(3)));
            end else if (r < 85) begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) send_reduce(pick_value(), k == len - 1);
            end else begin
                lv = $urandom_range(3);
                if (chk.held[lv] > 0) begin
                    idx = $urandom_range(chk.held[lv] - 1);
                    send_insert(chk.pair_key[lv][idx][KEY_W-1:VALUE_W],
                                chk.pair_key[lv][idx][VALUE_W-1:0], LEVEL_W'(lv));
                end else begin
                    send_insert(pick_value(), pick_value(), LEVEL_W'(lv));
                end
            end
            if ($urandom_range(49) == 0) wait_drained();
        end
    endtask

    initial begin
        int k;
        chk            = new();
        idle_pct       = 0;
        items_sent     = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = pitu_pkg::KIND_INSERT;
        i_left_value   = '0;
        i_right_value  = '0;
        i_level        = '0;
        i_last_element = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Highest start index: one identifier left, then the counter is exhausted.
        write_start_index(16'hFFFF);
        send_insert(16'hFFFF, 16'hFFFF, 2'd3);
        send_insert(16'h0000, 16'h0000, 2'd0);
        send_insert(16'hFFFF, 16'hFFFF, 2'd3);

        write_start_index(16'h0000);
        send_insert(16'h0000, 16'h0000, 2'd0);
        send_insert(16'h1234, 16'hABCD, 2'd0);
        send_insert(16'h0000, 16'h0001, 2'd1);
        send_reduce(16'h0000, 1'b0);
        send_reduce(16'h0000, 1'b0);
        send_reduce(16'h0001, 1'b1);
        // Single-element vector.
        send_reduce(16'hFFFF, 1'b1);
        send_reduce(16'h0005, 1'b0);
        send_reduce(16'h0007, 1'b1);
        // Lookup miss on a pair that was never stored.
        send_reduce(16'h0009, 1'b0);
        send_reduce(16'h0009, 1'b0);
        send_reduce(16'h0003, 1'b1);
        // An insert in the middle of a vector leaves the stream alone.
        send_reduce(16'h1234, 1'b0);
        send_insert(16'h0001, 16'h0002, 2'd2);
        send_reduce(16'hABCD, 1'b0);
        send_reduce(16'h0055, 1'b1);
        // Long vector: position reaches its maximum and lookups run past the last level.
        for (k = 0; k < 8; k++) send_reduce(16'h0000, k == 7);

        write_start_index(VALUE_W'($urandom_range(1, 255)));
        run_random(22, 140);
        write_start_index(VALUE_W'($urandom));
        run_random(85, 140);
        write_start_index(VALUE_W'($urandom_range(0, 16'h7FFF)));
        run_random(0, 140);

        // Fill the top level, then try one more new pair, an existing one and a reduce vector.
        write_start_index(16'h0000);
        idle_pct = 0;
        k = 0;
        while (chk.held[3] < ENTRIES) begin
            send_insert(16'hA5A5 ^ k[15:0], k[15:0], 2'd3);
            k++;
        end
        send_insert(16'hFFFE, 16'hFFFE, 2'd3);
        send_insert(chk.pair_key[3][0][KEY_W-1:VALUE_W], chk.pair_key[3][0][VALUE_W-1:0],
                    2'd3);
        for (k = 0; k < 6; k++) send_reduce(pick_value(), k == 5);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (chk.mismatches == 0 && chk.awaited.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
